// ===== src/nearest_neighbor_image_scaler_top_assert.svh =====
// assertion macros for the nearest neighbor image scaler checker
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_TOP_ASSERT_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_TOP_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define NNIS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nnis check failed");

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define NNIS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nnis check failed");

`endif

// ===== src/nnis_pkg.sv =====
// shared constants, register indexes and controller/datapath link types
package nnis_pkg;

    localparam int NNIS_MAX_WIDTH  = 256;
    localparam int NNIS_MAX_HEIGHT = 256;
    localparam int NNIS_CHANNELS   = 3;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 4;
    localparam int CH_W      = 8;
    localparam int COORD_W   = 8;

    // divider operand widths: num = 2*d*s + t, den = 2*t, quotient clamped below 2^CFG_W
    localparam int QUOT_W = CFG_W;
    localparam int NUM_W  = 2 * CFG_W + 2;
    localparam int DEN_W  = CFG_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_W = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SRC_H = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DST_W = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DST_H = CFG_IDX_W'(3);

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EMIT = 1'b1;

    typedef struct packed {
        logic load;
        logic emit;
        logic mul;
        logic div_start;
        logic div_sel_y;
        logic cap_x;
        logic cap_y;
        logic addr;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== src/nnis_ram.sv =====
// generic simple dual port ram with registered read
module nnis_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/nnis_div.sv =====
// iterative restoring divider, one quotient bit per cycle, result clamped to a limit
module nnis_div import nnis_pkg::*; #(
    parameter int NW = NUM_W,
    parameter int DW = DEN_W,
    parameter int QW = QUOT_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [QW-1:0] i_limit,
    output logic          o_done,
    output logic [QW-1:0] o_quot
);

    localparam int SH_W  = DW + QW;
    localparam int CW    = (NW > SH_W) ? NW : SH_W;
    localparam int CNT_W = $clog2(QW + 1);

    logic [CW-1:0]    r_rem;
    logic [CW-1:0]    r_dsh;
    logic [QW-1:0]    r_q;
    logic [QW-1:0]    r_limit;
    logic             r_ovf;
    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;

    logic [CW-1:0] num_ext;
    logic [CW-1:0] den_top;
    logic          ge;

    assign num_ext = CW'(i_num);
    assign den_top = CW'(i_den) << QW;
    assign ge      = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= num_ext;
            r_dsh   <= CW'(i_den) << (QW - 1);
            r_q     <= '0;
            r_limit <= i_limit;
            // quotient would not fit in QW bits: it is above any limit
            r_ovf   <= (num_ext >= den_top);
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q   <= QW'({r_q, ge});
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_ovf || (r_q > r_limit)) ? r_limit : r_q;

endmodule

// ===== src/nnis_ctrl.sv =====
// controller state machine for load and emit sequencing
module nnis_ctrl import nnis_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     i_func,
    output logic     o_ready,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_STARTX,
        S_WAITX,
        S_STARTY,
        S_WAITY,
        S_ADDR,
        S_READ,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_func == FUNC_EMIT) begin
                        o_cmd.emit = 1'b1;
                        n_state    = S_MUL;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_STARTX;
            end
            S_STARTX: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_WAITX;
            end
            S_WAITX: begin
                if (i_stat.div_done) begin
                    o_cmd.cap_x = 1'b1;
                    n_state     = S_STARTY;
                end
            end
            S_STARTY: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel_y = 1'b1;
                n_state         = S_WAITY;
            end
            S_WAITY: begin
                o_cmd.div_sel_y = 1'b1;
                if (i_stat.div_done) begin
                    o_cmd.cap_y = 1'b1;
                    n_state     = S_ADDR;
                end
            end
            S_ADDR: begin
                o_cmd.addr = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

// ===== src/nnis_dp.sv =====
// datapath: config registers, counters, coordinate mapping, frame store, output register
module nnis_dp import nnis_pkg::*; #(
    parameter int MAX_WIDTH  = NNIS_MAX_WIDTH,
    parameter int MAX_HEIGHT = NNIS_MAX_HEIGHT,
    parameter int CHANNELS   = NNIS_CHANNELS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic [CH_W-1:0]      i_in_red,
    input  logic [CH_W-1:0]      i_in_green,
    input  logic [CH_W-1:0]      i_in_blue,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [CH_W-1:0]      o_out_red,
    output logic [CH_W-1:0]      o_out_green,
    output logic [CH_W-1:0]      o_out_blue,
    output logic [COORD_W-1:0]   o_dest_x,
    output logic [COORD_W-1:0]   o_dest_y,
    output logic                 o_frame_end
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int STORED = (CHANNELS < 3) ? CHANNELS : 3;
    localparam int DW     = CH_W * STORED;
    localparam int PW     = 2 * CFG_W;
    localparam int LW     = ((AW > PW) ? AW : PW) + 1;

    function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v, input int maxv);
        logic [CFG_W-1:0] res;
        if (v == '0) begin
            res = CFG_W'(1);
        end else if (int'(v) > maxv) begin
            res = CFG_W'(maxv);
        end else begin
            res = v;
        end
        return res;
    endfunction

    logic [CFG_W-1:0] r_src_w;
    logic [CFG_W-1:0] r_src_h;
    logic [CFG_W-1:0] r_dst_w;
    logic [CFG_W-1:0] r_dst_h;

    logic [AW-1:0]    r_load_idx;
    logic [CFG_W-1:0] r_col;
    logic [CFG_W-1:0] r_row;

    logic [CFG_W-1:0]  r_dx;
    logic [CFG_W-1:0]  r_dy;
    logic              r_last;
    logic [NUM_W-1:0]  r_num_x;
    logic [NUM_W-1:0]  r_num_y;
    logic [QUOT_W-1:0] r_sx;
    logic [QUOT_W-1:0] r_sy;
    logic [AW-1:0]     r_raddr;

    logic               r_ovalid;
    logic [CH_W-1:0]    r_out_ch [3];
    logic [COORD_W-1:0] r_out_x;
    logic [COORD_W-1:0] r_out_y;
    logic               r_out_end;

    logic [CFG_W-1:0] sw;
    logic [CFG_W-1:0] sh;
    logic [CFG_W-1:0] tw;
    logic [CFG_W-1:0] th;

    assign sw = eff_size(r_src_w, MAX_WIDTH);
    assign sh = eff_size(r_src_h, MAX_HEIGHT);
    assign tw = eff_size(r_dst_w, MAX_WIDTH);
    assign th = eff_size(r_dst_h, MAX_HEIGHT);

    // load address advance
    logic [PW-1:0] total;
    logic [LW-1:0] idx_inc;
    logic          load_wrap;

    assign total     = PW'(sw) * PW'(sh);
    assign idx_inc   = LW'(r_load_idx) + LW'(1);
    assign load_wrap = (idx_inc >= LW'(total));

    // emit position advance
    logic row_end;
    logic col_last_row;

    assign row_end      = ((CFG_W + 1)'(r_col) + (CFG_W + 1)'(1)) >= (CFG_W + 1)'(tw);
    assign col_last_row = ((CFG_W + 1)'(r_row) + (CFG_W + 1)'(1)) >= (CFG_W + 1)'(th);

    // rounding numerators 2*d*s + t
    logic [PW-1:0]    prod_x;
    logic [PW-1:0]    prod_y;
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;

    assign prod_x = PW'(r_dx) * PW'(sw);
    assign prod_y = PW'(r_dy) * PW'(sh);
    assign num_x  = NUM_W'({prod_x, 1'b0}) + NUM_W'(tw);
    assign num_y  = NUM_W'({prod_y, 1'b0}) + NUM_W'(th);

    // shared divider
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic [QUOT_W-1:0] div_limit;
    logic              div_done;
    logic [QUOT_W-1:0] div_quot;

    assign div_num   = i_cmd.div_sel_y ? r_num_y : r_num_x;
    assign div_den   = i_cmd.div_sel_y ? {th, 1'b0} : {tw, 1'b0};
    assign div_limit = i_cmd.div_sel_y ? QUOT_W'(sh - CFG_W'(1)) : QUOT_W'(sw - CFG_W'(1));

    nnis_div #(
        .NW (NUM_W),
        .DW (DEN_W),
        .QW (QUOT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_limit (div_limit),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // store address sy*sw + sx, below the store depth by construction
    logic [PW:0] addr_full;

    assign addr_full = (PW + 1)'(r_sy) * (PW + 1)'(sw) + (PW + 1)'(r_sx);

    // frame store
    logic [CH_W-1:0] in_ch [3];
    logic [CH_W-1:0] rd_ch [3];
    logic [DW-1:0]   wdata;
    logic [DW-1:0]   rdata;

    assign in_ch[0] = i_in_red;
    assign in_ch[1] = i_in_green;
    assign in_ch[2] = i_in_blue;

    for (genvar c = 0; c < 3; c++) begin : g_ch
        if (c < STORED) begin : g_stored
            assign wdata[c*CH_W +: CH_W] = in_ch[c];
            assign rd_ch[c]              = rdata[c*CH_W +: CH_W];
        end else begin : g_absent
            assign rd_ch[c] = '0;
        end
    end

    nnis_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (r_load_idx),
        .i_wdata (wdata),
        .i_raddr (r_raddr),
        .o_rdata (rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w    <= CFG_W'(256);
            r_src_h    <= CFG_W'(256);
            r_dst_w    <= CFG_W'(256);
            r_dst_h    <= CFG_W'(256);
            r_load_idx <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_SRC_W: r_src_w <= i_cfg_data;
                    REG_SRC_H: r_src_h <= i_cfg_data;
                    REG_DST_W: r_dst_w <= i_cfg_data;
                    REG_DST_H: r_dst_h <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load) begin
                r_load_idx <= load_wrap ? '0 : AW'(idx_inc);
            end
            if (i_cmd.emit) begin
                if (row_end) begin
                    r_col <= '0;
                    r_row <= col_last_row ? '0 : r_row + CFG_W'(1);
                end else begin
                    r_col <= r_col + CFG_W'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_dx   <= r_col;
            r_dy   <= r_row;
            r_last <= row_end && col_last_row;
        end
        if (i_cmd.mul) begin
            r_num_x <= num_x;
            r_num_y <= num_y;
        end
        if (i_cmd.cap_x) begin
            r_sx <= div_quot;
        end
        if (i_cmd.cap_y) begin
            r_sy <= div_quot;
        end
        if (i_cmd.addr) begin
            r_raddr <= AW'(addr_full);
        end
        if (i_cmd.out_load) begin
            r_out_ch[0] <= rd_ch[0];
            r_out_ch[1] <= rd_ch[1];
            r_out_ch[2] <= rd_ch[2];
            r_out_x     <= r_dx[COORD_W-1:0];
            r_out_y     <= r_dy[COORD_W-1:0];
            r_out_end   <= r_last;
        end
    end

    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_ovalid || i_ready;

    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign o_out_red   = r_out_ch[0];
    assign o_out_green = r_out_ch[1];
    assign o_out_blue  = r_out_ch[2];
    assign o_dest_x    = r_out_x;
    assign o_dest_y    = r_out_y;
    assign o_frame_end = r_out_end;

endmodule

// ===== src/nearest_neighbor_image_scaler_top.sv =====
// top level of the nearest neighbor image scaler: controller plus datapath
// load item (func 0): written to the frame store at its accepting edge, no result; one per cycle while idle
// emit item (func 1): no new item is taken until its result is loaded into the output register;
//   two divider passes (start, quotient bits, capture) plus a registered store read
// a finished result waits in the output register while the next item is taken
// reset is synchronous, active low: clears counters, sizes (to 256) and valid flags;
//   the frame store is not cleared and holds garbage until loaded
module nearest_neighbor_image_scaler_top import nnis_pkg::*; #(
    parameter int MAX_WIDTH  = NNIS_MAX_WIDTH,
    parameter int MAX_HEIGHT = NNIS_MAX_HEIGHT,
    parameter int CHANNELS   = NNIS_CHANNELS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input item channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_func,
    input  logic [CH_W-1:0]      i_in_red,
    input  logic [CH_W-1:0]      i_in_green,
    input  logic [CH_W-1:0]      i_in_blue,
    // result item channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [CH_W-1:0]      o_out_red,
    output logic [CH_W-1:0]      o_out_green,
    output logic [CH_W-1:0]      o_out_blue,
    output logic [COORD_W-1:0]   o_dest_x,
    output logic [COORD_W-1:0]   o_dest_y,
    output logic                 o_frame_end,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // command and status link between controller and datapath
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer: accepts items, steps the divider twice per emit, hands off to output reg
    nnis_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .o_ready (o_ready),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    // datapath: sizes, raster counters, rounding numerators, divider, frame store, output reg
    nnis_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CHANNELS   (CHANNELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_red    (i_in_red),
        .i_in_green  (i_in_green),
        .i_in_blue   (i_in_blue),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_dest_x    (o_dest_x),
        .o_dest_y    (o_dest_y),
        .o_frame_end (o_frame_end)
    );

endmodule

// ===== src/nnis_checker.sv =====
// port-level assertion checker for the scaler top, bound to it
`include "nearest_neighbor_image_scaler_top_assert.svh"

module nnis_checker import nnis_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input logic                 i_func,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [CH_W-1:0]      o_out_red,
    input logic [CH_W-1:0]      o_out_green,
    input logic [CH_W-1:0]      o_out_blue,
    input logic [COORD_W-1:0]   o_dest_x,
    input logic [COORD_W-1:0]   o_dest_y,
    input logic                 o_frame_end
);

    logic [3*CH_W+2*COORD_W:0] out_payload;

    assign out_payload = {o_out_red, o_out_green, o_out_blue, o_dest_x, o_dest_y, o_frame_end};

    // a stalled result holds
    `NNIS_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(out_payload))

    // an emit item occupies the block, a load item does not
    `NNIS_ASSERT_NEXT(a_emit_busy, i_valid && o_ready && (i_func == FUNC_EMIT), !o_ready)
    `NNIS_ASSERT_NEXT(a_load_free, i_valid && o_ready && (i_func == FUNC_LOAD), o_ready)

    // a new result only shows up at the end of emit work
    `NNIS_ASSERT_NOW(a_result_after_work, $rose(o_valid), !$past(o_ready))

endmodule

bind nearest_neighbor_image_scaler_top nnis_checker u_checker (.*);

// ===== tb/tb_nearest_neighbor_image_scaler_top.sv =====
// self-checking testbench for the nearest neighbor image scaler top level
module tb_nearest_neighbor_image_scaler_top;
    import nnis_pkg::*;

    localparam int STORE_DEPTH   = NNIS_MAX_WIDTH * NNIS_MAX_HEIGHT;
    localparam int CYCLE_LIMIT   = 1000000;
    // loads leave nothing behind to wait for
    localparam int SETTLE_CYCLES = 40;

    // register indexes past the last real one, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = CFG_IDX_W'(15);

    typedef struct {
        logic [CH_W-1:0]    red;
        logic [CH_W-1:0]    green;
        logic [CH_W-1:0]    blue;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } t_scaled_pixel;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 i_func      = FUNC_LOAD;
    logic [CH_W-1:0]      i_in_red    = '0;
    logic [CH_W-1:0]      i_in_green  = '0;
    logic [CH_W-1:0]      i_in_blue   = '0;
    logic                 i_ready     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_SRC_W;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 o_ready;
    logic                 o_valid;
    logic [CH_W-1:0]      o_out_red;
    logic [CH_W-1:0]      o_out_green;
    logic [CH_W-1:0]      o_out_blue;
    logic [COORD_W-1:0]   o_dest_x;
    logic [COORD_W-1:0]   o_dest_y;
    logic                 o_frame_end;
    logic                 o_cfg_ready;

    nearest_neighbor_image_scaler_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_in_red    (i_in_red),
        .i_in_green  (i_in_green),
        .i_in_blue   (i_in_blue),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_dest_x    (o_dest_x),
        .o_dest_y    (o_dest_y),
        .o_frame_end (o_frame_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // scaler mirror: register copies, counters and the frame store contents
    logic [CFG_W-1:0]    cfg_src_w = CFG_W'(256);
    logic [CFG_W-1:0]    cfg_src_h = CFG_W'(256);
    logic [CFG_W-1:0]    cfg_dst_w = CFG_W'(256);
    logic [CFG_W-1:0]    cfg_dst_h = CFG_W'(256);
    int unsigned         load_pos  = 0;
    int unsigned         emit_x    = 0;
    int unsigned         emit_y    = 0;
    logic [3*CH_W-1:0]   pixel_mem    [STORE_DEPTH];
    bit                  pixel_loaded [STORE_DEPTH];
    t_scaled_pixel       expected_pixels [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int errors        = 0;
    int cycle_count   = 0;

    // zero counts as one, anything past the maximum counts as the maximum
    function automatic int unsigned eff_size(logic [CFG_W-1:0] v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // round(d*s/t) with halves up, clamped to the last source column or row
    function automatic int unsigned nearest_src(int unsigned d, int unsigned s, int unsigned t);
        int unsigned q;
        q = (2 * d * s + t) / (2 * t);
        if (q > s - 1) q = s - 1;
        return q;
    endfunction

    function automatic int unsigned next_emit_addr();
        int unsigned sw, sx, sy;
        sw = eff_size(cfg_src_w, NNIS_MAX_WIDTH);
        sx = nearest_src(emit_x, sw, eff_size(cfg_dst_w, NNIS_MAX_WIDTH));
        sy = nearest_src(emit_y, eff_size(cfg_src_h, NNIS_MAX_HEIGHT),
                         eff_size(cfg_dst_h, NNIS_MAX_HEIGHT));
        return (sy * sw + sx) % STORE_DEPTH;
    endfunction

    function automatic bit frame_ready();
        int unsigned total;
        total = eff_size(cfg_src_w, NNIS_MAX_WIDTH) * eff_size(cfg_src_h, NNIS_MAX_HEIGHT);
        for (int unsigned a = 0; a < total; a++) begin
            if (!pixel_loaded[a]) return 0;
        end
        return 1;
    endfunction

    // advance the mirror by one accepted item
    task automatic scale_step(logic func, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                              logic [CH_W-1:0] b);
        int unsigned tw, th, addr;
        bit row_end;
        t_scaled_pixel px;
        tw = eff_size(cfg_dst_w, NNIS_MAX_WIDTH);
        th = eff_size(cfg_dst_h, NNIS_MAX_HEIGHT);
        if (func == FUNC_LOAD) begin
            addr = load_pos % STORE_DEPTH;
            pixel_mem[addr]    = {r, g, b};
            pixel_loaded[addr] = 1'b1;
            if (load_pos + 1 >= eff_size(cfg_src_w, NNIS_MAX_WIDTH) *
                                eff_size(cfg_src_h, NNIS_MAX_HEIGHT))
                load_pos = 0;
            else
                load_pos++;
        end else begin
            addr = next_emit_addr();
            {px.red, px.green, px.blue} = pixel_mem[addr];
            px.col  = COORD_W'(emit_x);
            px.row  = COORD_W'(emit_y);
            row_end = (emit_x + 1 >= tw);
            px.last = row_end && (emit_y + 1 >= th);
            expected_pixels.push_back(px);
            // counters beyond a shrunken size wrap on this advance
            if (row_end) begin
                emit_x = 0;
                emit_y = px.last ? 0 : emit_y + 1;
            end else begin
                emit_x++;
            end
        end
    endtask

    // one item on the input channel; called and returns at a falling edge
    task automatic send_item(logic func, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                             logic [CH_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid    = 1'b1;
        i_func     = func;
        i_in_red   = r;
        i_in_green = g;
        i_in_blue  = b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        scale_step(func, r, g, b);
        @(negedge i_clk);
    endtask

    task automatic send_load();
        send_item(FUNC_LOAD, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
    endtask

    task automatic send_emit();
        send_item(FUNC_EMIT, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
    endtask

    // emits only where the pixel it reads has been loaded
    task automatic send_mixed(int emit_pct);
        if ($urandom_range(99) < emit_pct && pixel_loaded[next_emit_addr()])
            send_emit();
        else
            send_load();
    endtask

    task automatic fill_frame();
        while (!frame_ready()) send_load();
    endtask

    // drop valid, let every expected pixel come back, then let the block settle
    task automatic wait_idle();
        i_valid = 1'b0;
        while (expected_pixels.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_SRC_W: cfg_src_w = data;
            REG_SRC_H: cfg_src_h = data;
            REG_DST_W: cfg_dst_w = data;
            REG_DST_H: cfg_dst_h = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_sizes(int sw, int sh, int tw, int th);
        wait_idle();
        write_reg(REG_SRC_W, CFG_W'(sw));
        write_reg(REG_SRC_H, CFG_W'(sh));
        write_reg(REG_DST_W, CFG_W'(tw));
        write_reg(REG_DST_H, CFG_W'(th));
    endtask

    task automatic set_idling(int send_pct, int rx_pct);
        send_idle_pct = send_pct;
        stall_pct     = rx_pct;
    endtask

    // 2x2 source to 3x2 target: pixel extremes, frame end, emit and load wrap
    task automatic test_small_frame();
        set_sizes(2, 2, 3, 2);
        send_item(FUNC_LOAD, 8'h00, 8'h00, 8'h00);
        send_item(FUNC_LOAD, 8'hFF, 8'hFF, 8'hFF);
        send_item(FUNC_LOAD, 8'hAA, 8'h55, 8'h0F);
        send_item(FUNC_LOAD, 8'h55, 8'hAA, 8'hF0);
        repeat (7) send_emit();
    endtask

    // zero and oversized register values, ignored register indexes
    task automatic test_size_limits();
        set_sizes(0, 1, 511, 0);
        write_reg(REG_UNUSED_LO, CFG_W'(0));
        write_reg(REG_UNUSED_HI, CFG_W'(511));
        write_reg(CFG_IDX_W'($urandom_range(4, 15)), CFG_W'($urandom));
        send_load();
        repeat (3) send_emit();
        // column now past the new target width, next emit closes the frame
        set_sizes(0, 1, 2, 0);
        repeat (2) send_emit();
    endtask

    // target shrinks while the output counters are in the middle of a frame
    task automatic test_resize_midframe();
        set_sizes(2, 2, 5, 4);
        fill_frame();
        repeat (7) send_emit();
        set_sizes(2, 2, 2, 1);
        repeat (2) send_emit();
    endtask

    // small random frames loaded in full, then loads and emits mixed
    task automatic test_random_frames(int send_pct, int rx_pct);
        int sw, sh, tw, th;
        set_idling(send_pct, rx_pct);
        repeat (4) begin
            sw = $urandom_range(1, 8);
            sh = $urandom_range(1, 8);
            tw = $urandom_range(1, 12);
            th = $urandom_range(1, 12);
            case ($urandom_range(7))
                0: sw = 0;
                1: sh = 0;
                2: tw = $urandom_range(257, 511);
                3: th = 0;
                4: th = $urandom_range(257, 511);
                default: ;
            endcase
            set_sizes(sw, sh, tw, th);
            fill_frame();
            repeat (80) send_mixed(60);
        end
    endtask

    // full-width and full-height source lines
    task automatic test_wide_frames();
        set_idling(26, 26);
        set_sizes(256, 1, $urandom_range(128, 256), 2);
        fill_frame();
        repeat (150) send_mixed(70);
        set_sizes(1, 300, 1, $urandom_range(2, 256));
        fill_frame();
        repeat (100) send_mixed(70);
        set_sizes(1, 256, 256, 1);
        repeat (40) send_mixed(70);
    endtask

    always @(negedge i_clk) i_ready <= ($urandom_range(99) >= stall_pct);

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_scaled_pixel want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: result with none expected, actual x %0d y %0d", $time,
                         o_dest_x, o_dest_y);
                errors++;
            end else begin
                want = expected_pixels.pop_front();
                compare_field("red", want.red, o_out_red);
                compare_field("green", want.green, o_out_green);
                compare_field("blue", want.blue, o_out_blue);
                compare_field("dest_x", want.col, o_dest_x);
                compare_field("dest_y", want.row, o_dest_y);
                compare_field("frame_end", want.last, o_frame_end);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_small_frame();
        test_size_limits();
        test_resize_midframe();
        test_random_frames(0, 0);
        test_random_frames(88, 0);
        test_random_frames(0, 88);
        test_random_frames(26, 26);
        test_wide_frames();
        wait_idle();
        if (errors == 0 && expected_pixels.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/nnis_pkg.sv
src/nnis_ram.sv
src/nnis_div.sv
src/nnis_ctrl.sv
src/nnis_dp.sv
src/nearest_neighbor_image_scaler_top.sv
src/nnis_checker.sv
tb/tb_nearest_neighbor_image_scaler_top.sv
